// File: hw/rtl/srrw_pkg.sv
// Shared widths, codes and controller/datapath interface types for the receive window.
package srrw_pkg;

    localparam int WINDOW_MAX  = 32;                  // slot count, power of two
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int SEQ_W       = 32;
    localparam int HANDLE_W    = 16;
    localparam int LEN_W       = 11;
    localparam int WIN_W       = 6;
    localparam int PAYLOAD_MAX = 1472;
    localparam int TDATA_W     = 64;                  // seq + handle + length, byte padded
    localparam int FIELDS_W    = SEQ_W + HANDLE_W + LEN_W;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

    localparam logic OP_DATA      = 1'b0;
    localparam logic OP_END       = 1'b1;
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Source of a result beat
    localparam logic [1:0] SRC_INPUT   = 2'd0;
    localparam logic [1:0] SRC_SLOT    = 2'd1;
    localparam logic [1:0] SRC_ACK_EXP = 2'd2;
    localparam logic [1:0] SRC_ACK_SEQ = 2'd3;

    typedef struct packed {
        logic       latch_in;
        logic       emit;
        logic [1:0] out_sel;
        logic       out_last;
        logic       out_fin;
        logic       use_flush;
        logic       clr_cur;
        logic       exp_inc;
        logic       store;
        logic       load_pend;
        logic       clr_pend;
        logic       cnt_load;
        logic       cnt_inc;
        logic       finish;
    } srrw_cmd_t;

    typedef struct packed {
        logic done;
        logic op_end;
        logic seq_eq_exp;
        logic in_window;
        logic cur_valid;
        logic pend_cur;
        logic pend_rest_empty;
        logic pend_init_empty;
        logic cnt_max;
        logic out_free;
    } srrw_status_t;

endpackage

// File: hw/rtl/srrw_ctrl.sv
// Controller state machine: sequences accept, release chain, ack and end flush.
module srrw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  srrw_pkg::srrw_status_t status,
    output srrw_pkg::srrw_cmd_t    cmd
);
    import srrw_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_CHAIN = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // beats arriving after the end packet are taken and dropped
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.latch_in = 1'b1;
                    if (!status.done) begin
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.op_end) begin
                        cmd.out_sel  = SRC_ACK_SEQ;
                        cmd.out_fin  = 1'b1;
                        cmd.out_last = status.pend_init_empty;
                        if (status.pend_init_empty) begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.load_pend = 1'b1;
                            cmd.cnt_load  = 1'b1;
                            state_next    = ST_FLUSH;
                        end
                    end else if (status.seq_eq_exp) begin
                        cmd.out_sel  = SRC_INPUT;
                        cmd.clr_cur  = 1'b1;
                        cmd.exp_inc  = 1'b1;
                        cmd.cnt_load = 1'b1;
                        state_next   = ST_CHAIN;
                    end else begin
                        cmd.store    = status.in_window;
                        cmd.out_sel  = SRC_ACK_EXP;
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_CHAIN: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.cur_valid && !status.cnt_max) begin
                        cmd.out_sel = SRC_SLOT;
                        cmd.clr_cur = 1'b1;
                        cmd.exp_inc = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end else begin
                        cmd.out_sel  = SRC_ACK_EXP;
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                cmd.use_flush = 1'b1;
                if (status.pend_cur) begin
                    if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.out_sel  = SRC_SLOT;
                        cmd.out_fin  = 1'b1;
                        cmd.out_last = status.pend_rest_empty;
                        cmd.clr_pend = 1'b1;
                        if (status.pend_rest_empty) begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/srrw_datapath.sv
// Datapath: window state, slot store, pending mask and the output register.
module srrw_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [srrw_pkg::WIN_W-1:0]     cfg_wr_data,
    input  logic [srrw_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                           s_tuser,
    input  srrw_pkg::srrw_cmd_t            cmd,
    output srrw_pkg::srrw_status_t         status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srrw_pkg::TDATA_W-1:0]   m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import srrw_pkg::*;

    logic [WIN_W-1:0]      window_reg;
    logic [SEQ_W-1:0]      exp_reg, exp_next;
    logic                  done_reg;
    logic [WINDOW_MAX-1:0] valid_reg, valid_next;
    logic [WINDOW_MAX-1:0] pend_reg, pend_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;

    logic [HANDLE_W-1:0]   slot_handle [WINDOW_MAX];
    logic [LEN_W-1:0]      slot_length [WINDOW_MAX];

    logic                  op_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [LEN_W-1:0]      length_reg;

    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic [1:0]            m_tuser_reg;
    logic                  m_tlast_reg;

    logic [LEN_W-1:0]      in_length, in_length_clamped;
    logic [WIN_W-1:0]      win_eff;
    logic [SEQ_W:0]        bound;
    logic [SEQ_W-1:0]      cur_seq;
    logic [IDX_W-1:0]      cur_idx, exp_idx, seq_idx;
    logic [WINDOW_MAX-1:0] cur_onehot, exp_onehot;
    logic                  out_kind;
    logic [SEQ_W-1:0]      out_num;
    logic [HANDLE_W-1:0]   out_handle;
    logic [LEN_W-1:0]      out_length;

    // Saturate overlong payloads on the way in
    assign in_length         = s_tdata[SEQ_W+HANDLE_W +: LEN_W];
    assign in_length_clamped = (in_length > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX)
                                                                 : in_length;

    always_comb begin
        if (window_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (window_reg > WIN_W'(WINDOW_MAX)) begin
            win_eff = WIN_W'(WINDOW_MAX);
        end else begin
            win_eff = window_reg;
        end
    end

    assign bound      = {1'b0, exp_reg} + (SEQ_W+1)'(win_eff) - (SEQ_W+1)'(1);
    assign cur_seq    = cmd.use_flush ? exp_reg + SEQ_W'(cnt_reg) + SEQ_W'(1) : exp_reg;
    assign cur_idx    = cur_seq[IDX_W-1:0];
    assign exp_idx    = exp_reg[IDX_W-1:0];
    assign seq_idx    = seq_reg[IDX_W-1:0];
    assign cur_onehot = WINDOW_MAX'(1) << cur_idx;
    assign exp_onehot = WINDOW_MAX'(1) << exp_idx;

    assign status.done            = done_reg;
    assign status.op_end          = (op_reg == OP_END);
    assign status.seq_eq_exp      = (seq_reg == exp_reg);
    assign status.in_window       = (seq_reg > exp_reg) && ({1'b0, seq_reg} <= bound);
    assign status.cur_valid       = valid_reg[cur_idx];
    assign status.pend_cur        = pend_reg[cur_idx];
    assign status.pend_rest_empty = ~|(pend_reg & ~cur_onehot);
    assign status.pend_init_empty = ~|(valid_reg & ~exp_onehot);
    assign status.cnt_max         = (cnt_reg == IDX_W'(WINDOW_MAX - 1));
    assign status.out_free        = !m_tvalid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (cmd.finish) begin
            valid_next = '0;
        end else begin
            if (cmd.store) begin
                valid_next[seq_idx] = 1'b1;
            end
            if (cmd.clr_cur) begin
                valid_next[cur_idx] = 1'b0;
            end
        end

        pend_next = pend_reg;
        if (cmd.load_pend) begin
            pend_next = valid_reg & ~exp_onehot;
        end else if (cmd.clr_pend) begin
            pend_next[cur_idx] = 1'b0;
        end

        exp_next = cmd.exp_inc ? exp_reg + SEQ_W'(1) : exp_reg;

        cnt_next = cnt_reg;
        if (cmd.cnt_load) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_comb begin
        unique case (cmd.out_sel)
            SRC_INPUT: begin
                out_kind   = KIND_RELEASE;
                out_num    = seq_reg;
                out_handle = handle_reg;
                out_length = length_reg;
            end
            SRC_SLOT: begin
                out_kind   = KIND_RELEASE;
                out_num    = cur_seq;
                out_handle = slot_handle[cur_idx];
                out_length = slot_length[cur_idx];
            end
            SRC_ACK_EXP: begin
                out_kind   = KIND_ACK;
                out_num    = exp_reg;
                out_handle = '0;
                out_length = '0;
            end
            SRC_ACK_SEQ: begin
                out_kind   = KIND_ACK;
                out_num    = seq_reg;
                out_handle = '0;
                out_length = '0;
            end
            default: begin
                out_kind   = KIND_ACK;
                out_num    = '0;
                out_handle = '0;
                out_length = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= WINDOW_RESET;
            exp_reg      <= '0;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            pend_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            exp_reg   <= exp_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            if (cmd.finish) begin
                done_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg     <= s_tuser;
            seq_reg    <= s_tdata[SEQ_W-1:0];
            handle_reg <= s_tdata[SEQ_W +: HANDLE_W];
            length_reg <= in_length_clamped;
        end
        if (cmd.store) begin
            slot_handle[seq_idx] <= handle_reg;
            slot_length[seq_idx] <= length_reg;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {(TDATA_W-FIELDS_W)'(0), out_length, out_handle, out_num};
            m_tuser_reg <= {cmd.out_fin, out_kind};
            m_tlast_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: hw/rtl/selective_repeat_receive_window_unit.sv
// Top level of the selective-repeat receive window.
//
// Slave stream: one beat per packet descriptor. tuser is the packet kind (data or end),
// tdata carries sequence number, payload handle and length. Master stream: one beat per
// result, either a packet released in order or an acknowledgement; tlast marks the final
// result of a descriptor and tuser[1] marks results of the end packet.
// Timing: a descriptor is taken and latched; its first result is loaded into the output
// register once that register is free, and further results of an in-order release chain
// follow one per cycle while it stays free. A data packet that is stored or dropped gives
// one ack. An end packet walks the stored slots one per cycle after its ack, holes included,
// waiting at a stored slot while the output is full, and stops after the last stored one.
// The walk and the chain run in the controller, one slot per cycle while the output is free, so
// the next descriptor is taken only once the previous one has issued all of its results; the
// output register lets the next descriptor in while the last result still waits for m_tready.
// Reset (aresetn low, synchronous) clears the expected number, all slot valid bits and the
// finished flag, and sets the window to 8; s_tready stays low while aresetn is low. The
// window register is written through cfg_wr_en while the block is idle; the user must keep
// to this, as the block itself does not enforce it. When the receiver stalls, the output
// register holds its beat and the controller waits; nothing is dropped. After an end packet
// the block takes and drops every further beat until reset.
module selective_repeat_receive_window_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [srrw_pkg::WIN_W-1:0]   cfg_wr_data,   // receive window width
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [srrw_pkg::TDATA_W-1:0] s_tdata,       // seq_num, payload_handle, payload_length
    input  logic                         s_tuser,       // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [srrw_pkg::TDATA_W-1:0] m_tdata,       // ack_or_seq, out_handle, out_length
    output logic [1:0]                   m_tuser,       // kind, finished
    output logic                         m_tlast        // last
);
    import srrw_pkg::*;

    srrw_cmd_t    cmd;
    srrw_status_t status;

    // Sequence each descriptor
    srrw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold window state and drive result beats
    srrw_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: hw/rtl/srrw_checker.sv
// Port-level checker for the receive window, bound to the top level.
module srrw_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [srrw_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);
    import srrw_pkg::*;

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Nothing follows the final beat of an end packet
    a_silent_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast && m_tuser[1] |=> !m_tvalid)
        else $error("result beat after end packet completed");

    // Acks carry no handle and no length
    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_ACK) |-> m_tdata[FIELDS_W-1:SEQ_W] == '0)
        else $error("ack beat carries payload fields");

    // A data-packet ack always closes its descriptor
    a_data_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_ACK) && !m_tuser[1] |-> m_tlast)
        else $error("data ack not marked last");

    // Released lengths are saturated
    a_len_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_RELEASE)
        |-> m_tdata[FIELDS_W-1:SEQ_W+HANDLE_W] <= LEN_W'(PAYLOAD_MAX))
        else $error("released length above maximum");

endmodule

bind selective_repeat_receive_window_unit srrw_checker u_srrw_checker (.*);

// File: tb/tb_selective_repeat_receive_window_unit.sv
// Self-checking testbench for the selective-repeat receive window: scoreboard, drivers, checks.
module tb_selective_repeat_receive_window_unit;
    import srrw_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_PCT    = 19;
    localparam int SETTLE_CYC  = WINDOW_MAX + 8;   // end packet walks up to WINDOW_MAX-1 slots
    localparam int PHASE_BEATS = 56;

    // One result beat as the block should present it
    typedef struct packed {
        logic                kind;
        logic [SEQ_W-1:0]    num;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
        logic                last;
        logic                fin;
    } rx_beat_t;

    // Predicts the release and ack beats of each accepted descriptor and matches the
    // beats that come out against them, oldest first.
    class rx_window_scoreboard;
        logic [WIN_W-1:0]    window_reg;
        logic [SEQ_W-1:0]    next_seq;
        bit                  held [WINDOW_MAX];
        logic [HANDLE_W-1:0] held_handle [WINDOW_MAX];
        logic [LEN_W-1:0]    held_length [WINDOW_MAX];
        bit                  ended;
        rx_beat_t            owed [$];
        int                  errors;

        function new();
            window_reg = WINDOW_RESET;
            next_seq   = '0;
            foreach (held[i]) held[i] = 1'b0;
            ended  = 1'b0;
            errors = 0;
        endfunction

        // Zero acts as one, anything above the slot count as the slot count
        function int unsigned eff_window();
            int unsigned w;
            w = window_reg;
            if (w < 1) w = 1;
            if (w > WINDOW_MAX) w = WINDOW_MAX;
            return w;
        endfunction

        function void owe(input logic kind, input logic [SEQ_W-1:0] num,
                          input logic [HANDLE_W-1:0] handle, input logic [LEN_W-1:0] length,
                          input logic fin);
            rx_beat_t b;
            b.kind   = kind;
            b.num    = num;
            b.handle = handle;
            b.length = length;
            b.last   = 1'b0;
            b.fin    = fin;
            owed.push_back(b);
        endfunction

        function void take_packet(input logic op, input logic [SEQ_W-1:0] seq,
                                  input logic [HANDLE_W-1:0] handle,
                                  input logic [LEN_W-1:0] length);
            logic [LEN_W-1:0] len;
            logic [SEQ_W:0]   bound;
            logic [SEQ_W-1:0] s;
            logic [IDX_W-1:0] idx;
            rx_beat_t         tail;
            int               i;
            if (ended) return;
            len = (length > PAYLOAD_MAX) ? LEN_W'(PAYLOAD_MAX) : length;
            if (op == OP_DATA) begin
                if (seq == next_seq) begin
                    held[seq[IDX_W-1:0]] = 1'b0;
                    owe(KIND_RELEASE, seq, handle, len, 1'b0);
                    next_seq = next_seq + 1;
                    // release the stored run up to the first hole
                    for (i = 0; i < WINDOW_MAX - 1; i++) begin
                        idx = next_seq[IDX_W-1:0];
                        if (!held[idx]) break;
                        owe(KIND_RELEASE, next_seq, held_handle[idx], held_length[idx], 1'b0);
                        held[idx] = 1'b0;
                        next_seq  = next_seq + 1;
                    end
                end else begin
                    bound = {1'b0, next_seq} + eff_window() - 1;
                    if (seq > next_seq && {1'b0, seq} <= bound) begin
                        idx = seq[IDX_W-1:0];
                        held[idx]        = 1'b1;
                        held_handle[idx] = handle;
                        held_length[idx] = len;
                    end
                end
                owe(KIND_ACK, next_seq, '0, '0, 1'b0);
            end else begin
                owe(KIND_ACK, seq, '0, '0, 1'b1);
                for (i = 1; i < WINDOW_MAX; i++) begin
                    s   = next_seq + i;
                    idx = s[IDX_W-1:0];
                    if (held[idx]) owe(KIND_RELEASE, s, held_handle[idx], held_length[idx], 1'b1);
                end
                foreach (held[j]) held[j] = 1'b0;
                ended = 1'b1;
            end
            tail      = owed.pop_back();
            tail.last = 1'b1;
            owed.push_back(tail);
        endfunction

        task flag_mismatch(input string what);
            errors++;
            if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
        endtask

        task match_beat(input logic [TDATA_W-1:0] data, input logic [1:0] user,
                        input logic last);
            rx_beat_t want;
            string    tag;
            if (owed.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                        data, user, last));
                return;
            end
            want = owed.pop_front();
            tag  = $sformatf("beat num=%0d", want.num);
            if (user[0] !== want.kind)
                flag_mismatch($sformatf("%s kind %b, want %b", tag, user[0], want.kind));
            if (data[SEQ_W-1:0] !== want.num)
                flag_mismatch($sformatf("%s ack_or_seq %0d", tag, data[SEQ_W-1:0]));
            if (data[SEQ_W+HANDLE_W-1:SEQ_W] !== want.handle)
                flag_mismatch($sformatf("%s handle %h, want %h", tag,
                                        data[SEQ_W+HANDLE_W-1:SEQ_W], want.handle));
            if (data[FIELDS_W-1:SEQ_W+HANDLE_W] !== want.length)
                flag_mismatch($sformatf("%s length %0d, want %0d", tag,
                                        data[FIELDS_W-1:SEQ_W+HANDLE_W], want.length));
            if (data[TDATA_W-1:FIELDS_W] !== '0)
                flag_mismatch($sformatf("%s padding %h", tag, data[TDATA_W-1:FIELDS_W]));
            if (last !== want.last)
                flag_mismatch($sformatf("%s last %b, want %b", tag, last, want.last));
            if (user[1] !== want.fin)
                flag_mismatch($sformatf("%s finished %b, want %b", tag, user[1], want.fin));
        endtask
    endclass

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [WIN_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    bit                  steady = 1'b0;     // high: neither side idles
    int                  cycles = 0;
    rx_window_scoreboard sb = new();

    selective_repeat_receive_window_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: stall at random, except through the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check every beat that the receiver takes
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.match_beat(m_tdata, m_tuser, m_tlast);
    end

    // Give up on a hung block
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            sb.flag_mismatch($sformatf("timeout, %0d beats still owed", sb.owed.size()));
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one descriptor, after a random gap, and hold it until taken. tvalid stays
    // high on return so that back-to-back beats need no second assignment in one step.
    task automatic send_item(input logic op, input logic [SEQ_W-1:0] seq,
                             input logic [HANDLE_W-1:0] handle,
                             input logic [LEN_W-1:0] length);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(TDATA_W-FIELDS_W){1'b0}}, length, handle, seq};
        do @(posedge aclk); while (!s_tready);
        sb.take_packet(op, seq, handle, length);
    endtask

    // Old, far, just-outside and near-ahead data packets
    task automatic send_noise();
        logic [SEQ_W-1:0] seq;
        case ($urandom_range(0, 3))
            0:       seq = sb.next_seq - $urandom_range(1, 8);
            1:       seq = $urandom;
            2:       seq = sb.next_seq + sb.eff_window() + $urandom_range(0, 3);
            default: seq = sb.next_seq + $urandom_range(1, 40);
        endcase
        send_item(OP_DATA, seq, HANDLE_W'($urandom), LEN_W'($urandom));
    endtask

    // Send a run of consecutive numbers from the expected one in shuffled order, with
    // some noise and some dropped beats. With hold_base set the run spans the whole
    // window and only the expected number is withheld, so the rest stays stored.
    task automatic run_block(input bit hold_base, output int beats);
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] tmp;
        int               span;
        int               j;
        int               k;
        base  = sb.next_seq;
        span  = hold_base ? sb.eff_window() : $urandom_range(1, sb.eff_window());
        beats = 0;
        for (j = 0; j < span; j++) order.push_back(base + j);
        for (j = span - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        for (j = 0; j < span; j++) begin
            if ($urandom_range(0, 99) < 12) begin
                send_noise();
                beats++;
            end
            if (hold_base ? (order[j] != base) : ($urandom_range(0, 99) >= 6)) begin
                send_item(OP_DATA, order[j], HANDLE_W'($urandom), LEN_W'($urandom));
                beats++;
            end
        end
    endtask

    // Drop tvalid, wait for every owed beat, then let any trailing walk finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        sb.window_reg = value;
    endtask

    initial begin
        logic [WIN_W-1:0] plan [7];
        int               p;
        int               sent;
        int               got;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset window of 8
        send_item(OP_DATA, 32'd0, 16'hFFFF, 11'h7FF);          // in order, length saturates
        send_item(OP_DATA, 32'd3, 16'h0000, 11'd0);            // store
        send_item(OP_DATA, 32'd3, 16'hA5A5, 11'd1472);         // duplicate overwrites
        send_item(OP_DATA, 32'd8, 16'h5A5A, 11'd1473);         // top edge of the window
        send_item(OP_DATA, 32'd9, 16'h1234, 11'd100);          // one past the window: drop
        send_item(OP_DATA, 32'd0, 16'h4321, 11'd5);            // already delivered: drop
        send_item(OP_DATA, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF);  // far ahead: drop
        send_item(OP_DATA, 32'd2, 16'h00FF, 11'd1);
        send_item(OP_DATA, 32'd1, 16'hFF00, 11'd2046);         // release 1..3, halt at hole 4
        send_item(OP_DATA, 32'd4, 16'h8001, 11'd1471);         // release 4 alone
        send_item(OP_DATA, 32'd6, 16'h7FFE, 11'd1024);
        send_item(OP_DATA, 32'd7, 16'h0F0F, 11'd512);
        send_item(OP_DATA, 32'd5, 16'hF0F0, 11'd2000);         // release 5..8

        // Window settings: extremes, out-of-range values, and a random one
        plan[0] = 6'd1;
        plan[1] = 6'd32;
        plan[2] = 6'd0;
        plan[3] = 6'd63;
        plan[4] = 6'd5;
        plan[5] = 6'd33;
        plan[6] = WIN_W'($urandom_range(2, 63));

        for (p = 0; p < 7; p++) begin
            settle();
            write_window(plan[p]);
            steady = (p == 3);
            // Fill the window behind a hole, then close it for the longest release chain
            run_block(1'b1, got);
            sent = got;
            send_item(OP_DATA, sb.next_seq, HANDLE_W'($urandom), LEN_W'($urandom));
            sent++;
            while (sent < PHASE_BEATS) begin
                run_block(1'b0, got);
                sent += got;
            end
            // Leave stored packets behind so that the next setting inherits them
            run_block(1'b1, got);
        end
        steady = 1'b0;

        // End packet flushes what is stored; everything after it is ignored
        settle();
        send_item(OP_END, $urandom, HANDLE_W'($urandom), LEN_W'($urandom));
        repeat (4) send_item(OP_DATA, sb.next_seq, HANDLE_W'($urandom), LEN_W'($urandom));
        settle();

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
